// ===== hdl/rpn_pkg.sv =====
// shared types and constants for the postfix expression evaluator
// no dependencies; used by the top level and the arithmetic unit

package rpn_pkg;

    // ascii codes of the accepted symbols
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_STAR  = 8'h2A;
    localparam logic [7:0] SYM_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_CHAR  = 3'd1,
        STATUS_UNDERFLOW = 3'd2,
        STATUS_DIV_ZERO  = 3'd3,
        STATUS_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    // request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CALC,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_PREP,
        A_RUN,
        A_FIX,
        A_DONE
    } alu_state_t;

endpackage

// ===== hdl/rpn_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rpn_alu.sv =====
// bit-serial arithmetic unit: add and subtract one bit per cycle, multiply by
// shift and add, signed divide by restoring division; uses rpn_pkg

module rpn_alu #(
    parameter int W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rpn_pkg::alu_req_t req,
    input  logic [W-1:0]     left,
    input  logic [W-1:0]     right,
    output logic             done,
    output logic [W-1:0]     result
);

    localparam int CNT_W = $clog2(W + 1);

    rpn_pkg::alu_state_t state_reg, state_next;
    rpn_pkg::op_t        op_reg, op_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        y_reg, y_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic                carry_reg, carry_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                y_bit;
    logic                sum_bit;
    logic [W-1:0]        rem_sh;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        y_bit      = y_reg[0] ^ (op_reg == rpn_pkg::OP_SUB);
        sum_bit    = x_reg[0] ^ y_bit ^ carry_reg;
        rem_sh     = {acc_reg[W-2:0], x_reg[W-1]};

        unique case (state_reg)
            rpn_pkg::A_IDLE: begin
                if (req.start) begin
                    op_next    = req.op;
                    x_next     = left;
                    y_next     = right;
                    state_next = rpn_pkg::A_PREP;
                end
            end
            rpn_pkg::A_PREP: begin
                acc_next   = '0;
                cnt_next   = '0;
                carry_next = (op_reg == rpn_pkg::OP_SUB);
                if (op_reg == rpn_pkg::OP_DIV) begin
                    // work on magnitudes, fix the sign at the end
                    x_next   = x_reg[W-1] ? (W'(0) - x_reg) : x_reg;
                    y_next   = y_reg[W-1] ? (W'(0) - y_reg) : y_reg;
                    neg_next = x_reg[W-1] ^ y_reg[W-1];
                end
                state_next = rpn_pkg::A_RUN;
            end
            rpn_pkg::A_RUN: begin
                case (op_reg) inside
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
                        // lsb first, sum bits enter acc at the top
                        acc_next   = {sum_bit, acc_reg[W-1:1]};
                        carry_next = (x_reg[0] & y_bit) | (x_reg[0] & carry_reg)
                                   | (y_bit & carry_reg);
                        x_next     = {1'b0, x_reg[W-1:1]};
                        y_next     = {1'b0, y_reg[W-1:1]};
                    end
                    rpn_pkg::OP_MUL: begin
                        if (y_reg[0]) begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = {x_reg[W-2:0], 1'b0};
                        y_next = {1'b0, y_reg[W-1:1]};
                    end
                    default: begin
                        // quotient bits shift into x as dividend bits leave
                        if (rem_sh >= y_reg) begin
                            acc_next = rem_sh - y_reg;
                            x_next   = {x_reg[W-2:0], 1'b1};
                        end else begin
                            acc_next = rem_sh;
                            x_next   = {x_reg[W-2:0], 1'b0};
                        end
                    end
                endcase
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(W - 1)) begin
                    state_next = rpn_pkg::A_FIX;
                end
            end
            rpn_pkg::A_FIX: begin
                if (op_reg == rpn_pkg::OP_DIV) begin
                    acc_next = neg_reg ? (W'(0) - x_reg) : x_reg;
                end
                state_next = rpn_pkg::A_DONE;
            end
            rpn_pkg::A_DONE: begin
                state_next = rpn_pkg::A_IDLE;
            end
            default: begin
                state_next = rpn_pkg::A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpn_pkg::A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
    end

    assign done   = (state_reg == rpn_pkg::A_DONE);
    assign result = acc_reg;

`ifndef SYNTHESIS
    // a request only arrives while the unit is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == rpn_pkg::A_IDLE)
        else $error("alu started while busy");

    // done is a single-cycle pulse
    assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done)
        else $error("alu done held");

    // the bit counter never runs past the word
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rpn_pkg::A_RUN |-> cnt_reg <= CNT_W'(W - 1))
        else $error("alu counter overrun");
`endif

endmodule

// ===== hdl/postfix_expression_evaluator.sv =====
// postfix expression evaluator: sequencer, operand stack and result register
// depends on rpn_pkg, rpn_ram and rpn_alu

// - input channel s_*: one ascii character per word in s_symbol, s_is_last
//   marks the final character of an expression
// - digits push 0..9, + - * / pop right then left and push left op right;
//   arithmetic wraps at VALUE_WIDTH bits, division truncates toward zero
// - result channel m_*: one word per expression: m_value is the top of stack
//   (0 when empty or on error), m_status 0 ok, 1 bad char, 2 underflow,
//   3 divide by zero, 4 stack full; the first error sticks
// - one character in work at a time, s_ready is high only while idle
// - a digit, a rejected character or operator, or any character after an
//   error passes through decode and finish before the block is idle again
// - an operator passes through decode, the left operand ram read, the
//   bit-serial alu, writeback and idle
// - m_valid is registered and rises from the finish state of the final
//   character, after the alu when that character is an operator
// - while the receiver stalls the block keeps accepting characters and only
//   waits when the next result is ready and the output register is full
// - reset empties the stack and clears the error; ram contents stay, entries
//   above the stack count are never read; the top of stack sits in a register

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_symbol,
    input  logic               s_is_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value,
    output logic [2:0]         m_status
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    // control state
    rpn_pkg::ctl_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    rpn_pkg::status_t    err_reg, err_next;
    logic                m_valid_reg, m_valid_next;

    // payload
    logic [7:0]             sym_reg, sym_next;
    logic                   last_reg, last_next;
    logic [VALUE_WIDTH-1:0] tos_reg, tos_next;
    logic signed [31:0]     m_value_reg, m_value_next;
    rpn_pkg::status_t       m_status_reg, m_status_next;

    // decode of the held character
    logic                   is_digit;
    logic                   is_op;
    rpn_pkg::op_t           op_code;
    logic [7:0]             sym_off;
    logic [CNT_W-1:0]       below_cnt;
    logic [ADDR_W-1:0]      below_addr;
    logic signed [63:0]     tos_wide;

    // ram and alu hookup
    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [VALUE_WIDTH-1:0] ram_wr_data;
    logic                   ram_rd_en;
    logic [VALUE_WIDTH-1:0] ram_rd_data;
    rpn_pkg::alu_req_t      alu_req;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_result;

    assign sym_off    = sym_reg - rpn_pkg::SYM_ZERO;
    assign is_digit   = (sym_reg >= rpn_pkg::SYM_ZERO) && (sym_reg <= rpn_pkg::SYM_NINE);
    assign below_cnt  = count_reg - CNT_W'(2);
    assign below_addr = below_cnt[ADDR_W-1:0];
    assign tos_wide   = 64'(signed'(tos_reg));

    always_comb begin
        is_op   = 1'b1;
        op_code = rpn_pkg::OP_ADD;
        unique case (sym_reg)
            rpn_pkg::SYM_PLUS:  op_code = rpn_pkg::OP_ADD;
            rpn_pkg::SYM_MINUS: op_code = rpn_pkg::OP_SUB;
            rpn_pkg::SYM_STAR:  op_code = rpn_pkg::OP_MUL;
            rpn_pkg::SYM_SLASH: op_code = rpn_pkg::OP_DIV;
            default:            is_op = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        tos_next      = tos_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = count_reg[ADDR_W-1:0];
        ram_wr_data   = VALUE_WIDTH'(sym_off[3:0]);
        ram_rd_en     = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = op_code;
        s_ready       = (state_reg == rpn_pkg::ST_IDLE);

        // receiver drains the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rpn_pkg::ST_IDLE: begin
                if (s_valid) begin
                    sym_next   = s_symbol;
                    last_next  = s_is_last;
                    state_next = rpn_pkg::ST_DECODE;
                end
            end
            rpn_pkg::ST_DECODE: begin
                state_next = rpn_pkg::ST_DONE;
                if (err_reg == rpn_pkg::STATUS_OK) begin
                    if (is_digit) begin
                        if (count_reg == CNT_W'(STACK_DEPTH)) begin
                            err_next = rpn_pkg::STATUS_FULL;
                        end else begin
                            ram_wr_en  = 1'b1;
                            tos_next   = VALUE_WIDTH'(sym_off[3:0]);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (!is_op) begin
                        err_next = rpn_pkg::STATUS_BAD_CHAR;
                    end else if (count_reg < CNT_W'(2)) begin
                        err_next = rpn_pkg::STATUS_UNDERFLOW;
                    end else if (op_code == rpn_pkg::OP_DIV && tos_reg == '0) begin
                        err_next = rpn_pkg::STATUS_DIV_ZERO;
                    end else begin
                        // fetch the left operand, the right one is in tos_reg
                        ram_rd_en  = 1'b1;
                        state_next = rpn_pkg::ST_READ;
                    end
                end
            end
            rpn_pkg::ST_READ: begin
                alu_req.start = 1'b1;
                state_next    = rpn_pkg::ST_CALC;
            end
            rpn_pkg::ST_CALC: begin
                if (alu_done) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = below_addr;
                    ram_wr_data = alu_result;
                    tos_next    = alu_result;
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = rpn_pkg::ST_DONE;
                end
            end
            rpn_pkg::ST_DONE: begin
                if (!last_reg) begin
                    state_next = rpn_pkg::ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = err_reg;
                    if (err_reg == rpn_pkg::STATUS_OK && count_reg != '0) begin
                        m_value_next = tos_wide[31:0];
                    end else begin
                        m_value_next = '0;
                    end
                    count_next = '0;
                    err_next   = rpn_pkg::STATUS_OK;
                    state_next = rpn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rpn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpn_pkg::ST_IDLE;
            count_reg   <= '0;
            err_reg     <= rpn_pkg::STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        tos_reg      <= tos_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    // operand stack storage
    rpn_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (below_addr),
        .rd_data (ram_rd_data)
    );

    // bit-serial arithmetic, left operand straight from the ram read register
    rpn_alu #(
        .W(VALUE_WIDTH)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .left    (ram_rd_data),
        .right   (tos_reg),
        .done    (alu_done),
        .result  (alu_result)
    );

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    // stack count stays within the stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // one character in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a word while busy");

    // an error result always carries a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != rpn_pkg::STATUS_OK) |-> m_value == '0)
        else $error("error result with nonzero value");

    // the alu only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> state_reg == rpn_pkg::ST_CALC)
        else $error("alu finished outside calc");
`endif

endmodule

// ===== tb/postfix_expression_evaluator_checker.sv =====
// result checker for the postfix expression evaluator: follows every accepted word,
// keeps its own operand stack and compares each result word with the predicted one
// depends on rpn_pkg
`timescale 1ns / 100ps

module postfix_expression_evaluator_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_symbol,
    input  logic               s_is_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_value,
    input  logic [2:0]         m_status,
    output int                 error_count,
    output int                 results_owed
);

    typedef struct packed {
        logic signed [31:0] value;
        rpn_pkg::status_t   status;
    } expr_result_t;

    expr_result_t       result_queue[$];
    expr_result_t       oldest;
    logic signed [31:0] operand_mem[STACK_DEPTH];
    int                 operand_count = 0;
    rpn_pkg::status_t   sticky_status = rpn_pkg::STATUS_OK;
    int                 mismatches    = 0;

    // quotient truncated toward zero, worked on magnitudes so that the
    // most negative value over minus one wraps instead of overflowing
    function automatic logic signed [31:0] quotient(input logic signed [31:0] num,
                                                     input logic signed [31:0] den);
        logic [31:0] mag_num, mag_den, mag_quo;
        mag_num = num[31] ? 32'(-num) : 32'(num);
        mag_den = den[31] ? 32'(-den) : 32'(den);
        mag_quo = mag_num / mag_den;
        return (num[31] ^ den[31]) ? 32'(-mag_quo) : mag_quo;
    endfunction

    function automatic void take_symbol(input logic [7:0] sym);
        logic signed [31:0] lhs, rhs, res;
        if (sym >= rpn_pkg::SYM_ZERO && sym <= rpn_pkg::SYM_NINE) begin
            if (operand_count >= STACK_DEPTH) begin
                sticky_status = rpn_pkg::STATUS_FULL;
            end else begin
                operand_mem[operand_count] = 32'(sym - rpn_pkg::SYM_ZERO);
                operand_count++;
            end
        end else if (sym != rpn_pkg::SYM_PLUS && sym != rpn_pkg::SYM_MINUS &&
                     sym != rpn_pkg::SYM_STAR && sym != rpn_pkg::SYM_SLASH) begin
            sticky_status = rpn_pkg::STATUS_BAD_CHAR;
        end else if (operand_count < 2) begin
            sticky_status = rpn_pkg::STATUS_UNDERFLOW;
        end else begin
            rhs = operand_mem[operand_count - 1];
            lhs = operand_mem[operand_count - 2];
            case (sym)
                rpn_pkg::SYM_PLUS:  res = lhs + rhs;
                rpn_pkg::SYM_MINUS: res = lhs - rhs;
                rpn_pkg::SYM_STAR:  res = lhs * rhs;
                default: begin
                    if (rhs == 0) begin
                        sticky_status = rpn_pkg::STATUS_DIV_ZERO;
                        return;
                    end
                    res = quotient(lhs, rhs);
                end
            endcase
            operand_count--;
            operand_mem[operand_count - 1] = res;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            operand_count = 0;
            sticky_status = rpn_pkg::STATUS_OK;
            result_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $error("unexpected result word: value %0d status %0d", m_value, m_status);
                    mismatches++;
                end else begin
                    oldest = result_queue.pop_front();
                    if (m_value !== oldest.value) begin
                        $error("value: expected %0d, got %0d", oldest.value, m_value);
                        mismatches++;
                    end
                    if (m_status !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, m_status);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (sticky_status == rpn_pkg::STATUS_OK) begin
                    take_symbol(s_symbol);
                end
                if (s_is_last) begin
                    oldest.status = sticky_status;
                    if (sticky_status != rpn_pkg::STATUS_OK || operand_count == 0) begin
                        oldest.value = '0;
                    end else begin
                        oldest.value = operand_mem[operand_count - 1];
                    end
                    result_queue.push_back(oldest);
                    operand_count = 0;
                    sticky_status = rpn_pkg::STATUS_OK;
                end
            end
        end
        results_owed <= result_queue.size();
        error_count  <= mismatches;
    end

endmodule

// ===== tb/tb_postfix_expression_evaluator.sv =====
// top of the postfix expression evaluator testbench: clock, reset, character stimulus,
// result-side back pressure and the verdict
// depends on rpn_pkg, postfix_expression_evaluator and postfix_expression_evaluator_checker
`timescale 1ns / 100ps

module tb_postfix_expression_evaluator;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_symbol;
    logic               s_is_last;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_value;
    logic [2:0]         m_status;

    int error_count;
    int results_owed;

    // characters of the expression about to be sent
    logic [7:0] expr_chars[$];
    int         words_sent = 0;
    // remaining words of a stretch without idle cycles, one per side
    int         tx_quiet   = 0;
    int         rx_quiet   = 0;

    postfix_expression_evaluator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_symbol  (s_symbol),
        .s_is_last (s_is_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_status  (m_status)
    );

    postfix_expression_evaluator_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_status     (m_status),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // idle cycles before the next word: mostly a random gap, with occasional
    // stretches where the side never idles
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(10, 30);
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [7:0] digit(input int n);
        return rpn_pkg::SYM_ZERO + 8'(n);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return rpn_pkg::SYM_PLUS;
            1:       return rpn_pkg::SYM_MINUS;
            2:       return rpn_pkg::SYM_STAR;
            default: return rpn_pkg::SYM_SLASH;
        endcase
    endfunction

    // offer one word, starting and ending at a falling edge; valid stays
    // high straight into the next word when no gap is drawn
    task automatic send_word(input logic [7:0] sym, input logic last);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_symbol  <= sym;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // the queued characters as one expression, flag on the final one
    task automatic send_expression();
        foreach (expr_chars[i]) begin
            send_word(expr_chars[i], i == expr_chars.size() - 1);
        end
    endtask

    // well-formed expression: a random mix of pushes and operators that
    // always leaves exactly one operand on the stack
    task automatic build_expression(input int operands);
        int depth, pushed;
        depth  = 0;
        pushed = 0;
        expr_chars.delete();
        while (pushed < operands || depth > 1) begin
            if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                expr_chars.push_back(digit($urandom_range(0, 9)));
                depth++;
                pushed++;
            end else begin
                expr_chars.push_back(pick_operator());
                depth--;
            end
        end
    endtask

    // 16 digits fill the stack exactly, 17 or 18 run past it
    task automatic fill_stack();
        int n;
        n = $urandom_range(16, 18);
        expr_chars.delete();
        repeat (n) expr_chars.push_back(digit($urandom_range(0, 9)));
        repeat (n - 1) expr_chars.push_back(pick_operator());
        send_expression();
    endtask

    // 8^10 * 2 wraps to the most negative value, then divide by 0 - 1
    task automatic most_negative_over_minus_one();
        expr_chars.delete();
        expr_chars.push_back(digit(8));
        repeat (9) begin
            expr_chars.push_back(digit(8));
            expr_chars.push_back(rpn_pkg::SYM_STAR);
        end
        expr_chars.push_back(digit(2));
        expr_chars.push_back(rpn_pkg::SYM_STAR);
        expr_chars.push_back(digit(0));
        expr_chars.push_back(digit(1));
        expr_chars.push_back(rpn_pkg::SYM_MINUS);
        expr_chars.push_back(rpn_pkg::SYM_SLASH);
        send_expression();
    endtask

    // result side: random stalls per word, and once a long hold-off so the
    // output register stays full and the block backs up into its input
    initial begin : result_side
        int  gap;
        int  taken;
        bit  held;
        taken   = 0;
        held    = 1'b0;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (taken == 20 && !held) begin
                gap  = 400;
                held = 1'b1;
            end else begin
                gap = draw_gap(rx_quiet);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            @(negedge aclk);
        end
    end

    // hard stop in case a handshake never completes
    initial begin : watchdog
        #10_000_000;
        $display("tb_postfix_expression_evaluator: done, errors");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int operands;
        int pos;
        int n;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_symbol  = '0;
        s_is_last = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: each operation, negative results and truncating division
        expr_chars = {digit(3), digit(4), rpn_pkg::SYM_PLUS};
        send_expression();
        expr_chars = {digit(2), digit(9), rpn_pkg::SYM_MINUS};
        send_expression();
        expr_chars = {digit(7), digit(8), rpn_pkg::SYM_STAR};
        send_expression();
        expr_chars = {digit(0), digit(7), rpn_pkg::SYM_MINUS, digit(2), rpn_pkg::SYM_SLASH};
        send_expression();
        // divide by zero leaves the stack alone and sticks
        expr_chars = {digit(5), digit(0), rpn_pkg::SYM_SLASH};
        send_expression();
        // operator with an empty stack
        expr_chars = {rpn_pkg::SYM_PLUS};
        send_expression();
        // bad character at the bottom of the symbol range; the digit after it is ignored
        send_word(digit(1), 1'b0);
        send_word(8'h00, 1'b0);
        send_word(digit(2), 1'b1);
        // top of the symbol range as a lone final word
        send_word(8'hFF, 1'b1);

        fill_stack();
        most_negative_over_minus_one();

        // random part: mostly well-formed expressions, some corner sequences,
        // broken expressions and raw noise
        while (words_sent < 520) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                operands = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16)
                                                        : $urandom_range(1, 5);
                build_expression(operands);
                send_expression();
            end else if (kind == 12) begin
                fill_stack();
            end else if (kind == 13) begin
                most_negative_over_minus_one();
            end else if (kind < 17) begin
                // well-formed expression with one fault worked in
                build_expression($urandom_range(1, 6));
                pos = $urandom_range(0, expr_chars.size() - 1);
                case ($urandom_range(0, 2))
                    0: expr_chars[pos] = 8'($urandom_range(0, 255));
                    1: if (expr_chars.size() > 1) expr_chars.delete(pos);
                    default: expr_chars.push_front(pick_operator());
                endcase
                send_expression();
            end else begin
                // noise: any byte, end flag now and then
                n = $urandom_range(1, 6);
                repeat (n) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end

        s_valid <= 1'b0;
        while (results_owed != 0) @(posedge aclk);
        // allow a full operator time for any trailing word without a result
        repeat (80) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb_postfix_expression_evaluator: done, clean");
        end else begin
            $display("tb_postfix_expression_evaluator: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rpn_pkg.sv
hdl/rpn_ram.sv
hdl/rpn_alu.sv
hdl/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_checker.sv
tb/tb_postfix_expression_evaluator.sv
